FILE: hdl/bddf_pkg.sv
package bddf_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int PORT_W     = 16;
    localparam int CFG_W      = 32;
    localparam int IDX_W      = 3;
    localparam int CMP_W      = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    localparam logic [IDX_W-1:0] REG_PIN_MASK   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_PIN_INVERT = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_DEBOUNCE   = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_RISE_WAIT  = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_FALL_WAIT  = IDX_W'(4);

    localparam logic [PORT_W-1:0] PIN_MASK_RST = PORT_W'(1);
    localparam logic [CFG_W-1:0]  DEBOUNCE_RST = CFG_W'(50);

    typedef logic [TIME_WIDTH-1:0] t_time;

    typedef struct packed {
        logic [PORT_W-1:0] pin_mask;
        logic              pin_invert;
        logic [CFG_W-1:0]  debounce_ticks;
        logic [CFG_W-1:0]  rise_wait;
        logic [CFG_W-1:0]  fall_wait;
    } t_cfg;

    typedef struct packed {
        logic pressed;
        logic just_pressed;
        logic just_released;
        logic pressed_long;
        logic released_long;
    } t_result;

    function automatic logic [CMP_W-1:0] ext_time(input t_time t);
        logic [CMP_W-1:0] r;
        r = '0;
        r[TIME_WIDTH-1:0] = t;
        return r;
    endfunction

    function automatic logic [CMP_W-1:0] ext_cfg(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] r;
        r = '0;
        r[CFG_W-1:0] = v;
        return r;
    endfunction

endpackage

FILE: hdl/bddf_in_if.sv
interface bddf_in_if;
    logic                          valid;
    logic                          ready;
    logic [bddf_pkg::PORT_W-1:0]   port_word;
    logic [31:0]                   hold_ticks;

    modport source(output valid, output port_word, output hold_ticks, input ready);
    modport sink(input valid, input port_word, input hold_ticks, output ready);
endinterface

FILE: hdl/bddf_out_if.sv
interface bddf_out_if;
    logic valid;
    logic ready;
    logic pressed;
    logic just_pressed;
    logic just_released;
    logic pressed_long;
    logic released_long;

    modport source(output valid, output pressed, output just_pressed, output just_released,
                   output pressed_long, output released_long, input ready);
    modport sink(input valid, input pressed, input just_pressed, input just_released,
                 input pressed_long, input released_long, output ready);
endinterface

FILE: hdl/bddf_cfg.sv
module bddf_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bddf_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [bddf_pkg::CFG_W-1:0]   i_cfg_data,
    output bddf_pkg::t_cfg               o_cfg
);
    import bddf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pin_mask       <= PIN_MASK_RST;
            r_cfg.pin_invert     <= 1'b1;
            r_cfg.debounce_ticks <= DEBOUNCE_RST;
            r_cfg.rise_wait      <= '0;
            r_cfg.fall_wait      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PIN_MASK:   r_cfg.pin_mask       <= i_cfg_data[PORT_W-1:0];
                REG_PIN_INVERT: r_cfg.pin_invert     <= i_cfg_data[0];
                REG_DEBOUNCE:   r_cfg.debounce_ticks <= i_cfg_data;
                REG_RISE_WAIT:  r_cfg.rise_wait      <= i_cfg_data;
                REG_FALL_WAIT:  r_cfg.fall_wait      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/bddf_core.sv
module bddf_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bddf_pkg::t_cfg               i_cfg,
    input  logic                         i_step,
    input  logic [bddf_pkg::PORT_W-1:0]  i_port_word,
    input  logic [31:0]                  i_hold_ticks,
    output bddf_pkg::t_result            o_result
);
    import bddf_pkg::*;

    localparam t_time TIME_MAX = '1;

    logic  r_deb;
    logic  r_filt;
    t_time r_ticks;

    logic  n_deb;
    logic  n_filt;
    t_time n_ticks;

    logic  raw;
    t_time inc;
    logic  chg;
    logic [CMP_W-1:0] inc_x;
    logic [CMP_W-1:0] el_x;

    always_comb begin
        raw     = (|(i_port_word & i_cfg.pin_mask)) ^ i_cfg.pin_invert;
        inc     = (r_ticks == TIME_MAX) ? r_ticks : r_ticks + t_time'(1);
        inc_x   = ext_time(inc);
        chg     = (inc_x >= ext_cfg(i_cfg.debounce_ticks)) && (raw != r_deb);
        n_deb   = chg ? raw : r_deb;
        n_ticks = chg ? '0 : inc;
        el_x    = ext_time(n_ticks);
        n_filt  = r_filt;
        if (n_deb) begin
            if (el_x >= ext_cfg(i_cfg.rise_wait)) n_filt = 1'b1;
        end else begin
            if (el_x >= ext_cfg(i_cfg.fall_wait)) n_filt = 1'b0;
        end
        o_result.pressed       = n_filt;
        o_result.just_pressed  = n_filt && !r_filt;
        o_result.just_released = !n_filt && r_filt;
        o_result.pressed_long  = n_filt && (el_x >= ext_cfg(i_hold_ticks));
        o_result.released_long = !n_filt && (el_x >= ext_cfg(i_hold_ticks));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb   <= 1'b0;
            r_filt  <= 1'b0;
            r_ticks <= '0;
        end else if (i_step) begin
            r_deb   <= n_deb;
            r_filt  <= n_filt;
            r_ticks <= n_ticks;
        end
    end

endmodule

FILE: hdl/button_debounce_delay_filter_unit.sv
// Button debouncer with lockout and rise/fall delay filter.
// i_in: one beat per timer tick, carrying the sampled port word and the
//   hold-time threshold for the long-press and long-release queries.
// o_out: one beat per input beat, in order: filtered level, press and
//   release edges, pressed-long and released-long flags.
// Configuration: write i_cfg_idx/i_cfg_data with i_cfg_we high; registers are
//   pin mask, pin inversion, lockout ticks, rise wait, fall wait. Write only
//   while no tick is in flight.
// Path: a beat accepted into the input register is evaluated against the
//   debounce state, and its result is registered in the output register
//   once the output stage is free; the result is offered from that register.
// Throughput: one beat per cycle while o_out is taken; the state update is
//   a single increment and a few compares between input and result registers.
// Reset: synchronous, active low; clears the debounced and filtered levels,
//   the elapsed counter, both pipeline stages and loads the default registers.
// Stall: while o_out is not taken, the result holds and the input register
//   still fills; i_in.ready drops only when both stages are full.
module button_debounce_delay_filter_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bddf_in_if.sink                      i_in,
    bddf_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [bddf_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [bddf_pkg::CFG_W-1:0]   i_cfg_data
);
    import bddf_pkg::*;

    t_cfg    cfg;
    t_result res;

    logic              r_in_vld;
    logic [PORT_W-1:0] r_port_word;
    logic [31:0]       r_hold_ticks;
    logic              r_out_vld;
    t_result           r_res;

    logic out_free;
    logic step;
    logic in_free;

    assign out_free = !r_out_vld || o_out.ready;
    assign step     = r_in_vld && out_free;
    assign in_free  = !r_in_vld || step;

    assign i_in.ready = in_free;

    bddf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bddf_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_step       (step),
        .i_port_word  (r_port_word),
        .i_hold_ticks (r_hold_ticks),
        .o_result     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_free) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in.valid) begin
            r_port_word  <= i_in.port_word;
            r_hold_ticks <= i_in.hold_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.pressed       = r_res.pressed;
    assign o_out.just_pressed  = r_res.just_pressed;
    assign o_out.just_released = r_res.just_released;
    assign o_out.pressed_long  = r_res.pressed_long;
    assign o_out.released_long = r_res.released_long;

endmodule

FILE: bench/tb_button_debounce_delay_filter_unit.sv
module tb_button_debounce_delay_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bddf_pkg::*;

    localparam int NUM_DIR      = 28;
    localparam int NUM_PHASES   = 16;
    localparam int PHASE_TICKS  = 118;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SHOW_LIMIT   = 10;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [PORT_W-1:0] port;
        logic [31:0]       hold;
        logic              typed;
        t_result           want;
        t_cfg              cfg;
    } t_tick_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    bddf_in_if  tick_bus();
    bddf_out_if flag_bus();

    button_debounce_delay_filter_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_bus),
        .o_out      (flag_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // filter mirror
    t_cfg  flt_cfg;
    logic  deb_lvl;
    logic  filt_lvl;
    t_time since_change;

    t_result flags_q[$];
    logic    beat_typed;
    t_result beat_want;

    bit calm;
    int gap_pct;
    int stall_pct;
    int stall_left;
    int cycle_cnt;
    int ticks_in;
    int beats_out;
    int fail_cnt;
    int settings_cnt;

    t_tick_row dir_rows [NUM_DIR] = '{
        '{ROW_TICK, 16'h0001, 32'd0,          1'b1, 5'b00001, '0},
        '{ROW_TICK, 16'h0001, 32'hFFFF_FFFF,  1'b1, 5'b00000, '0},
        '{ROW_TICK, 16'h0000, 32'd0,          1'b1, 5'b00001, '0},
        '{ROW_TICK, 16'hFFFE, 32'd4,          1'b0, 5'b00000, '0},
        '{ROW_CFG,  16'h0000, 32'd0,          1'b0, 5'b00000,
          '{16'h8001, 1'b0, 32'd0, 32'd0, 32'd0}},
        '{ROW_TICK, 16'h8000, 32'd0,          1'b1, 5'b11010, '0},
        '{ROW_TICK, 16'h0001, 32'd1,          1'b0, 5'b00000, '0},
        '{ROW_TICK, 16'h7FFE, 32'd0,          1'b1, 5'b00101, '0},
        '{ROW_TICK, 16'hFFFF, 32'hFFFF_FFFF,  1'b0, 5'b00000, '0},
        '{ROW_CFG,  16'h0000, 32'd0,          1'b0, 5'b00000,
          '{16'h0000, 1'b0, 32'd0, 32'd0, 32'd0}},
        '{ROW_TICK, 16'hFFFF, 32'd0,          1'b1, 5'b00101, '0},
        '{ROW_CFG,  16'h0000, 32'd0,          1'b0, 5'b00000,
          '{16'h0000, 1'b1, 32'd0, 32'd0, 32'd0}},
        '{ROW_TICK, 16'h0000, 32'd0,          1'b1, 5'b11010, '0},
        '{ROW_CFG,  16'h0000, 32'd0,          1'b0, 5'b00000,
          '{16'h0004, 1'b0, 32'd3, 32'd2, 32'd4}},
        '{ROW_TICK, 16'h0000, 32'd2,          1'b0, 5'b00000, '0},
        '{ROW_TICK, 16'h0000, 32'd0,          1'b0, 5'b00000, '0},
        '{ROW_TICK, 16'h0000, 32'd1,          1'b0, 5'b00000, '0},
        '{ROW_TICK, 16'h0004, 32'd0,          1'b0, 5'b00000, '0},
        '{ROW_TICK, 16'h0000, 32'd3,          1'b0, 5'b00000, '0},
        '{ROW_TICK, 16'h0000, 32'd0,          1'b0, 5'b00000, '0},
        '{ROW_TICK, 16'h0000, 32'd5,          1'b0, 5'b00000, '0},
        '{ROW_TICK, 16'h0004, 32'd0,          1'b0, 5'b00000, '0},
        '{ROW_TICK, 16'h0004, 32'd1,          1'b0, 5'b00000, '0},
        '{ROW_TICK, 16'h0004, 32'd2,          1'b0, 5'b00000, '0},
        '{ROW_CFG,  16'h0000, 32'd0,          1'b0, 5'b00000,
          '{16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
        '{ROW_TICK, 16'h0000, 32'd0,          1'b0, 5'b00000, '0},
        '{ROW_TICK, 16'hFFFF, 32'hFFFF_FFFF,  1'b0, 5'b00000, '0},
        '{ROW_TICK, 16'h5A5A, 32'd1,          1'b0, 5'b00000, '0}
    };

    function automatic t_result step_filter(input logic [PORT_W-1:0] port,
                                            input logic [31:0] hold);
        logic    raw;
        logic    was_on;
        t_time   span;
        t_result r;
        raw    = |(port & flt_cfg.pin_mask);
        if (flt_cfg.pin_invert) begin
            raw = ~raw;
        end
        was_on = filt_lvl;
        span   = since_change;
        if (span != '1) begin
            span = span + t_time'(1);
        end
        if (span >= flt_cfg.debounce_ticks && raw != deb_lvl) begin
            deb_lvl = raw;
            span    = '0;
        end
        if (deb_lvl) begin
            if (span >= flt_cfg.rise_wait) begin
                filt_lvl = 1'b1;
            end
        end else if (span >= flt_cfg.fall_wait) begin
            filt_lvl = 1'b0;
        end
        since_change    = span;
        r.pressed       = filt_lvl;
        r.just_pressed  = filt_lvl & ~was_on;
        r.just_released = ~filt_lvl & was_on;
        r.pressed_long  = filt_lvl & (span >= hold);
        r.released_long = ~filt_lvl & (span >= hold);
        return r;
    endfunction

    function automatic logic [31:0] pick_span(input int top);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 7) begin
            return 32'd0;
        end else if (sel == 8) begin
            return 32'hFFFF_FFFF;
        end else if (sel == 9) begin
            return $urandom;
        end
        return $urandom_range(0, top);
    endfunction

    function automatic t_cfg pick_cfg();
        t_cfg c;
        int   sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            c.pin_mask = PORT_W'(1) << $urandom_range(0, PORT_W - 1);
        end else if (sel < 8) begin
            c.pin_mask = PORT_W'($urandom);
        end else if (sel == 8) begin
            c.pin_mask = '0;
        end else begin
            c.pin_mask = '1;
        end
        c.pin_invert     = 1'($urandom_range(0, 1));
        c.debounce_ticks = pick_span(8);
        c.rise_wait      = pick_span(12);
        c.fall_wait      = pick_span(12);
        return c;
    endfunction

    function automatic logic [31:0] pick_hold();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 7) begin
            return 32'd0;
        end else if (sel == 8) begin
            return 32'hFFFF_FFFF;
        end else if (sel == 9) begin
            return $urandom;
        end
        return $urandom_range(0, 40);
    endfunction

    function automatic logic [PORT_W-1:0] port_for_level(input logic lvl);
        logic [PORT_W-1:0] w;
        w = PORT_W'($urandom);
        if (!lvl) begin
            return w & ~flt_cfg.pin_mask;
        end
        w = w | (flt_cfg.pin_mask & PORT_W'($urandom));
        if ((w & flt_cfg.pin_mask) == '0) begin
            w = w | (flt_cfg.pin_mask & (~flt_cfg.pin_mask + PORT_W'(1)));
        end
        return w;
    endfunction

    task automatic send_tick(input logic [PORT_W-1:0] port, input logic [31:0] hold,
                             input logic typed, input t_result want);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            tick_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        tick_bus.valid      <= 1'b1;
        tick_bus.port_word  <= port;
        tick_bus.hold_ticks <= hold;
        beat_typed          <= typed;
        beat_want           <= want;
        @(posedge i_clk);
        while (!tick_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic load_config(input t_cfg c);
        tick_bus.valid <= 1'b0;
        while (flags_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        flt_cfg = c;
        write_reg(REG_PIN_MASK,   CFG_W'(c.pin_mask));
        write_reg(REG_PIN_INVERT, CFG_W'(c.pin_invert));
        write_reg(REG_DEBOUNCE,   c.debounce_ticks);
        write_reg(REG_RISE_WAIT,  c.rise_wait);
        write_reg(REG_FALL_WAIT,  c.fall_wait);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_cnt++;
    endtask

    task automatic run_phase(input int n_ticks);
        int   sent;
        int   run_len;
        int   bounce;
        logic lvl;
        logic pin;
        sent = 0;
        lvl  = 1'($urandom_range(0, 1));
        while (sent < n_ticks) begin
            if ($urandom_range(0, 4) == 0) begin
                run_len = $urandom_range(1, 8);
                repeat (run_len) begin
                    if (sent < n_ticks) begin
                        send_tick(PORT_W'($urandom), pick_hold(), 1'b0, '0);
                        sent++;
                    end
                end
            end else begin
                lvl     = ~lvl;
                pin     = lvl ^ flt_cfg.pin_invert;
                bounce  = $urandom_range(0, 4);
                run_len = $urandom_range(1, 30);
                repeat (bounce) begin
                    if (sent < n_ticks) begin
                        send_tick(port_for_level(1'($urandom_range(0, 1))), pick_hold(),
                                  1'b0, '0);
                        sent++;
                    end
                end
                repeat (run_len) begin
                    if (sent < n_ticks) begin
                        send_tick(port_for_level(pin), pick_hold(), 1'b0, '0);
                        sent++;
                    end
                end
            end
        end
    endtask

    // accept side: predict on every input beat, check every output beat
    always @(posedge i_clk) begin : scoreboard
        t_result pred;
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (tick_bus.valid && tick_bus.ready) begin
                pred = step_filter(tick_bus.port_word, tick_bus.hold_ticks);
                flags_q.push_back(beat_typed ? beat_want : pred);
                ticks_in++;
            end
            if (flag_bus.valid && flag_bus.ready) begin
                got.pressed       = flag_bus.pressed;
                got.just_pressed  = flag_bus.just_pressed;
                got.just_released = flag_bus.just_released;
                got.pressed_long  = flag_bus.pressed_long;
                got.released_long = flag_bus.released_long;
                if (flags_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= SHOW_LIMIT) begin
                        $display("result beat %0d with nothing pending: %b", beats_out, got);
                    end
                end else begin
                    want = flags_q.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= SHOW_LIMIT) begin
                            $display({"beat %0d mismatch: expected p=%b jp=%b jr=%b pl=%b",
                                      " rl=%b, got p=%b jp=%b jr=%b pl=%b rl=%b"},
                                     beats_out, want.pressed, want.just_pressed,
                                     want.just_released, want.pressed_long,
                                     want.released_long, got.pressed, got.just_pressed,
                                     got.just_released, got.pressed_long, got.released_long);
                        end
                    end
                end
                beats_out++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (calm) begin
            flag_bus.ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            flag_bus.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 11);
            flag_bus.ready <= 1'b0;
        end else begin
            flag_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt, flags_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = REG_PIN_MASK;
        i_cfg_data          = '0;
        tick_bus.valid      = 1'b0;
        tick_bus.port_word  = '0;
        tick_bus.hold_ticks = '0;
        flag_bus.ready      = 1'b0;
        beat_typed          = 1'b0;
        beat_want           = '0;
        calm                = 1'b0;
        gap_pct             = 10;
        stall_pct           = 10;
        stall_left          = 0;
        cycle_cnt           = 0;
        ticks_in            = 0;
        beats_out           = 0;
        fail_cnt            = 0;
        settings_cnt        = 1;

        flt_cfg.pin_mask       = PIN_MASK_RST;
        flt_cfg.pin_invert     = 1'b1;
        flt_cfg.debounce_ticks = DEBOUNCE_RST;
        flt_cfg.rise_wait      = '0;
        flt_cfg.fall_wait      = '0;
        deb_lvl      = 1'b0;
        filt_lvl     = 1'b0;
        since_change = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                load_config(dir_rows[r].cfg);
            end else begin
                send_tick(dir_rows[r].port, dir_rows[r].hold, dir_rows[r].typed,
                          dir_rows[r].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            load_config(pick_cfg());
            calm      = (ph == NUM_PHASES - 1);
            gap_pct   = $urandom_range(0, 3) * 8;
            stall_pct = $urandom_range(0, 3) * 8;
            run_phase(PHASE_TICKS);
        end

        // drain
        tick_bus.valid <= 1'b0;
        while (flags_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        fail_cnt += flags_q.size();

        $display("Covered %0d ticks (%0d directed rows) across %0d register settings,",
                 ticks_in, NUM_DIR, settings_cnt);
        $display("bounce, lockout, delay and hold-time cases; %0d results checked, %0d failures",
                 beats_out, fail_cnt);
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/bddf_pkg.sv
hdl/bddf_in_if.sv
hdl/bddf_out_if.sv
hdl/bddf_cfg.sv
hdl/bddf_core.sv
hdl/button_debounce_delay_filter_unit.sv
bench/tb_button_debounce_delay_filter_unit.sv
